[hdl/nlps_pkg.sv]
package nlps_pkg;

	localparam logic [1:0] OPC_APPEND = 2'd0;
	localparam logic [1:0] OPC_FETCH  = 2'd1;
	localparam logic [1:0] OPC_CLEAR  = 2'd2;

	localparam logic [2:0] KIND_FOR     = 3'd5;
	localparam logic [2:0] KIND_END_FOR = 3'd6;

	localparam logic [2:0] RK_WRITE     = 3'd0;
	localparam logic [2:0] RK_ISSUE     = 3'd1;
	localparam logic [2:0] RK_DONE      = 3'd2;
	localparam logic [2:0] RK_OK        = 3'd3;
	localparam logic [2:0] RK_UNMATCHED = 3'd4;
	localparam logic [2:0] RK_FULL      = 3'd5;

	typedef enum logic [1:0] {
		OP_APPEND,
		OP_FETCH,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [2:0]  kind;
		logic [7:0]  loop_var;
		logic [15:0] start_value;
		logic [15:0] end_value;
		logic [15:0] step_value;
	} item_t;

	typedef struct packed {
		logic [7:0]  loop_var;
		logic [15:0] start_value;
		logic [15:0] end_value;
		logic [15:0] step_value;
	} loop_fields_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOP,
		ST_READ,
		ST_SCAN,
		ST_FOR_WR,
		ST_FOR_ISS,
		ST_JUMP
	} state_t;

endpackage

[hdl/nlps_ram.sv]
module nlps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/nlps_front.sv]
module nlps_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	input  logic [2:0]           cmd_kind,
	input  logic [7:0]           loop_var,
	input  logic [15:0]          start_value,
	input  logic [15:0]          end_value,
	input  logic [15:0]          step_value,
	output logic                 q_valid,
	output nlps_pkg::item_t      q_item,
	input  logic                 q_pop
);

	nlps_pkg::item_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            known;
	logic            push;
	nlps_pkg::op_t   op;

	// Opcode three is taken and dropped here; it has no effect downstream.
	always_comb begin
		known = 1'b1;
		op    = nlps_pkg::OP_FETCH;
		unique case (opcode)
			nlps_pkg::OPC_APPEND: op = nlps_pkg::OP_APPEND;
			nlps_pkg::OPC_FETCH:  op = nlps_pkg::OP_FETCH;
			nlps_pkg::OPC_CLEAR:  op = nlps_pkg::OP_CLEAR;
			default:              known = 1'b0;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall && known;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{op: op, kind: cmd_kind, loop_var: loop_var,
				start_value: start_value, end_value: end_value,
				step_value: step_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

[hdl/nlps_back.sv]
module nlps_back #(
	parameter int PROGRAM_DEPTH = 256,
	parameter int STACK_DEPTH   = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  nlps_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [2:0]      result_kind,
	output logic [7:0]      command_index,
	output logic [2:0]      command_kind,
	output logic [7:0]      var_index,
	output logic [15:0]     var_value,
	output logic            stray_end,
	output logic            last
);

	localparam int AW = $clog2(PROGRAM_DEPTH);
	localparam int PW = $clog2(PROGRAM_DEPTH + 1);
	localparam int FW = $clog2(STACK_DEPTH + 1);
	localparam int TW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	nlps_pkg::state_t state_q, state_d;

	logic [PW-1:0] len_q, len_d;
	logic [PW-1:0] np_q, np_d;
	logic [FW-1:0] fc_q, fc_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [PW-1:0] scan_q, scan_d;
	logic [PW-1:0] depth_q, depth_d;
	logic [AW-1:0] endi_q, endi_d;
	nlps_pkg::loop_fields_t ff_q, ff_d;

	logic [AW-1:0] fr_body_q [STACK_DEPTH];
	logic [AW-1:0] fr_end_q  [STACK_DEPTH];
	logic [7:0]    fr_var_q  [STACK_DEPTH];
	logic [15:0]   fr_cur_q  [STACK_DEPTH];
	logic [15:0]   fr_st_q   [STACK_DEPTH];
	logic [15:0]   fr_en_q   [STACK_DEPTH];
	logic [15:0]   fr_sp_q   [STACK_DEPTH];

	logic          out_valid_q;
	logic [2:0]    rk_q;
	logic [7:0]    ci_q;
	logic [2:0]    ck_q;
	logic [7:0]    vi_q;
	logic [15:0]   vv_q;
	logic          stray_q;
	logic          last_q;

	logic          emit;
	logic [2:0]    e_rk;
	logic [7:0]    e_ci;
	logic [2:0]    e_ck;
	logic [7:0]    e_vi;
	logic [15:0]   e_vv;
	logic          e_stray;
	logic          e_last;

	logic          push_en;
	logic          upd_en;
	logic          we;
	logic [AW-1:0] rd_addr;
	logic [2:0]    rd_kind;
	nlps_pkg::loop_fields_t rd_fields;
	nlps_pkg::loop_fields_t wr_fields;

	logic          can_emit;
	logic [TW-1:0] top;
	logic          top_hit;
	logic [15:0]   cur_next;
	logic          go_top;
	logic          go_for;
	logic          full;
	logic          at_end;
	logic          scan_out;

	assign can_emit = !out_valid_q || !out_stall;
	assign top      = TW'(fc_q - 1'b1);
	assign top_hit  = (fc_q != '0) && (np_q == PW'(fr_end_q[top]));
	assign cur_next = fr_cur_q[top] + fr_sp_q[top];
	assign go_top   = (fr_sp_q[top] != 16'd0) ? (cur_next <= fr_en_q[top])
	                                          : (fr_st_q[top] == fr_en_q[top]);
	assign go_for   = (ff_q.step_value != 16'd0) ? (ff_q.start_value <= ff_q.end_value)
	                                             : (ff_q.start_value == ff_q.end_value);
	assign full     = (len_q == PW'(PROGRAM_DEPTH));
	assign at_end   = (np_q >= len_q);
	assign scan_out = (scan_q >= len_q);
	assign wr_fields = '{loop_var: q_item.loop_var, start_value: q_item.start_value,
		end_value: q_item.end_value, step_value: q_item.step_value};

	nlps_ram #(.WIDTH(3), .DEPTH(PROGRAM_DEPTH)) u_kinds (
		.clk   (clk),
		.we    (we),
		.waddr (len_q[AW-1:0]),
		.wdata (q_item.kind),
		.raddr (rd_addr),
		.rdata (rd_kind)
	);

	nlps_ram #(.WIDTH($bits(nlps_pkg::loop_fields_t)), .DEPTH(PROGRAM_DEPTH)) u_fields (
		.clk   (clk),
		.we    (we),
		.waddr (len_q[AW-1:0]),
		.wdata (wr_fields),
		.raddr (rd_addr),
		.rdata (rd_fields)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nlps_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (q_item.op == nlps_pkg::OP_FETCH) begin
						state_d = nlps_pkg::ST_TOP;
					end
				end
			end
			nlps_pkg::ST_TOP: begin
				if (top_hit) begin
					if (can_emit && go_top) begin
						state_d = nlps_pkg::ST_JUMP;
					end
				end else if (at_end) begin
					if (can_emit) begin
						state_d = nlps_pkg::ST_IDLE;
					end
				end else begin
					state_d = nlps_pkg::ST_READ;
				end
			end
			nlps_pkg::ST_READ: begin
				if (rd_kind == nlps_pkg::KIND_FOR) begin
					state_d = nlps_pkg::ST_SCAN;
				end else if (can_emit) begin
					state_d = nlps_pkg::ST_IDLE;
				end
			end
			nlps_pkg::ST_SCAN: begin
				if (scan_out) begin
					if (can_emit) begin
						state_d = nlps_pkg::ST_IDLE;
					end
				end else if (rd_kind == nlps_pkg::KIND_END_FOR && depth_q == '0) begin
					state_d = nlps_pkg::ST_FOR_WR;
				end
			end
			nlps_pkg::ST_FOR_WR: begin
				if (can_emit) begin
					state_d = nlps_pkg::ST_FOR_ISS;
				end
			end
			nlps_pkg::ST_FOR_ISS,
			nlps_pkg::ST_JUMP: begin
				if (can_emit) begin
					state_d = nlps_pkg::ST_IDLE;
				end
			end
			default: state_d = nlps_pkg::ST_IDLE;
		endcase
	end

	// Datapath, results and memory control.
	always_comb begin
		len_d   = len_q;
		np_d    = np_q;
		fc_d    = fc_q;
		pos_d   = pos_q;
		scan_d  = scan_q;
		depth_d = depth_q;
		endi_d  = endi_q;
		ff_d    = ff_q;
		emit    = 1'b0;
		e_rk    = '0;
		e_ci    = '0;
		e_ck    = '0;
		e_vi    = '0;
		e_vv    = '0;
		e_stray = 1'b0;
		e_last  = 1'b0;
		push_en = 1'b0;
		upd_en  = 1'b0;
		we      = 1'b0;
		q_pop   = 1'b0;
		rd_addr = np_q[AW-1:0];
		unique case (state_q)
			nlps_pkg::ST_IDLE: begin
				if (q_valid) begin
					if (q_item.op == nlps_pkg::OP_FETCH) begin
						q_pop = 1'b1;
					end else if (can_emit) begin
						q_pop  = 1'b1;
						emit   = 1'b1;
						e_last = 1'b1;
						if (q_item.op == nlps_pkg::OP_CLEAR) begin
							e_rk  = nlps_pkg::RK_OK;
							len_d = '0;
							np_d  = '0;
							fc_d  = '0;
						end else if (full) begin
							e_rk = nlps_pkg::RK_FULL;
						end else begin
							e_rk  = nlps_pkg::RK_OK;
							e_ci  = 8'(len_q);
							we    = 1'b1;
							len_d = len_q + 1'b1;
						end
					end
				end
			end
			nlps_pkg::ST_TOP: begin
				if (top_hit) begin
					rd_addr = fr_body_q[top];
					if (can_emit) begin
						emit   = 1'b1;
						e_rk   = nlps_pkg::RK_WRITE;
						e_vi   = fr_var_q[top];
						e_vv   = cur_next;
						upd_en = 1'b1;
						if (!go_top) begin
							fc_d = fc_q - 1'b1;
							np_d = np_q + 1'b1;
						end
					end
				end else if (at_end) begin
					if (can_emit) begin
						emit   = 1'b1;
						e_rk   = nlps_pkg::RK_DONE;
						e_last = 1'b1;
					end
				end
			end
			nlps_pkg::ST_READ: begin
				// A stalled plain command keeps its own entry on the read port.
				if (rd_kind == nlps_pkg::KIND_FOR) begin
					rd_addr = AW'(np_q + 1'b1);
					pos_d   = np_q[AW-1:0];
					ff_d    = rd_fields;
					scan_d  = np_q + 1'b1;
					depth_d = '0;
				end else if (can_emit) begin
					emit    = 1'b1;
					e_rk    = nlps_pkg::RK_ISSUE;
					e_ci    = 8'(np_q);
					e_ck    = rd_kind;
					e_stray = (rd_kind == nlps_pkg::KIND_END_FOR);
					e_last  = 1'b1;
					np_d    = np_q + 1'b1;
				end
			end
			nlps_pkg::ST_SCAN: begin
				rd_addr = AW'(scan_q + 1'b1);
				if (scan_out) begin
					if (can_emit) begin
						emit   = 1'b1;
						e_rk   = nlps_pkg::RK_UNMATCHED;
						e_ci   = 8'(pos_q);
						e_ck   = nlps_pkg::KIND_FOR;
						e_last = 1'b1;
					end
				end else if (rd_kind == nlps_pkg::KIND_FOR) begin
					depth_d = depth_q + 1'b1;
					scan_d  = scan_q + 1'b1;
				end else if (rd_kind == nlps_pkg::KIND_END_FOR) begin
					if (depth_q == '0) begin
						endi_d = scan_q[AW-1:0];
					end else begin
						depth_d = depth_q - 1'b1;
						scan_d  = scan_q + 1'b1;
					end
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end
			nlps_pkg::ST_FOR_WR: begin
				if (can_emit) begin
					emit = 1'b1;
					e_rk = nlps_pkg::RK_WRITE;
					e_vi = ff_q.loop_var;
					e_vv = ff_q.start_value;
					if (go_for) begin
						np_d = PW'(pos_q) + 1'b1;
						if (fc_q < FW'(STACK_DEPTH)) begin
							push_en = 1'b1;
							fc_d    = fc_q + 1'b1;
						end
					end else begin
						np_d = PW'(endi_q) + 1'b1;
					end
				end
			end
			nlps_pkg::ST_FOR_ISS: begin
				if (can_emit) begin
					emit   = 1'b1;
					e_rk   = nlps_pkg::RK_ISSUE;
					e_ci   = 8'(pos_q);
					e_ck   = nlps_pkg::KIND_FOR;
					e_last = 1'b1;
				end
			end
			nlps_pkg::ST_JUMP: begin
				rd_addr = fr_body_q[top];
				if (can_emit) begin
					emit   = 1'b1;
					e_rk   = nlps_pkg::RK_ISSUE;
					e_ci   = 8'(fr_body_q[top]);
					e_ck   = rd_kind;
					e_last = 1'b1;
					np_d   = PW'(fr_body_q[top]) + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nlps_pkg::ST_IDLE;
			len_q       <= '0;
			np_q        <= '0;
			fc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			len_q       <= len_d;
			np_q        <= np_d;
			fc_q        <= fc_d;
			out_valid_q <= emit || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		scan_q  <= scan_d;
		depth_q <= depth_d;
		endi_q  <= endi_d;
		ff_q    <= ff_d;
		if (emit) begin
			rk_q    <= e_rk;
			ci_q    <= e_ci;
			ck_q    <= e_ck;
			vi_q    <= e_vi;
			vv_q    <= e_vv;
			stray_q <= e_stray;
			last_q  <= e_last;
		end
		if (push_en) begin
			fr_body_q[fc_q[TW-1:0]] <= AW'(PW'(pos_q) + 1'b1);
			fr_end_q[fc_q[TW-1:0]]  <= endi_q;
			fr_var_q[fc_q[TW-1:0]]  <= ff_q.loop_var;
			fr_cur_q[fc_q[TW-1:0]]  <= ff_q.start_value;
			fr_st_q[fc_q[TW-1:0]]   <= ff_q.start_value;
			fr_en_q[fc_q[TW-1:0]]   <= ff_q.end_value;
			fr_sp_q[fc_q[TW-1:0]]   <= ff_q.step_value;
		end
		if (upd_en) begin
			fr_cur_q[top] <= cur_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_kind   = rk_q;
	assign command_index = ci_q;
	assign command_kind  = ck_q;
	assign var_index     = vi_q;
	assign var_value     = vv_q;
	assign stray_end     = stray_q;
	assign last          = last_q;

endmodule

[hdl/nested_loop_program_sequencer.sv]
// Channel   Handshake                  Payload
// input     in_valid / in_stall        opcode, cmd_kind, loop_var, start_value,
//                                      end_value, step_value
// output    out_valid / out_stall      result_kind, command_index, command_kind,
//                                      var_index, var_value, stray_end, last
//
// An append or a clear passes through the input queue and the output register.
// A plain fetch is dequeued, tests the top loop frame, reads the program store
// and hands its result over through the output register.
// A FOR then walks program entries in search of its END_FOR, through the single
// read port of the program store, before it writes its variable and issues.
// Each loop frame that retires in a fetch also emits a write of its variable.
// Reset clears the program length, position, frame count, the input queue and the
// output valid flag; the program store and frames hold no reset value and are
// only read once written.
// A stall on the output holds the sequencer at its next result; the two-entry
// input queue keeps taking transfers until it is full.
module nested_loop_program_sequencer #(
	parameter int PROGRAM_DEPTH = 256,
	parameter int STACK_DEPTH   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [2:0]  cmd_kind,
	input  logic [7:0]  loop_var,
	input  logic [15:0] start_value,
	input  logic [15:0] end_value,
	input  logic [15:0] step_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_kind,
	output logic [7:0]  command_index,
	output logic [2:0]  command_kind,
	output logic [7:0]  var_index,
	output logic [15:0] var_value,
	output logic        stray_end,
	output logic        last
);

	// Items that the front has classified and queued for the sequencer.
	logic            q_valid;
	logic            q_pop;
	nlps_pkg::item_t q_item;

	// The front decodes the opcode, drops unknown opcodes and buffers the rest.
	nlps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.cmd_kind    (cmd_kind),
		.loop_var    (loop_var),
		.start_value (start_value),
		.end_value   (end_value),
		.step_value  (step_value),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	// The back owns the program store, the loop stack and the output register.
	// It walks each fetch one step per cycle and emits one result per cycle
	// whenever the output register is free or being drained.
	nlps_back #(
		.PROGRAM_DEPTH (PROGRAM_DEPTH),
		.STACK_DEPTH   (STACK_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.command_index (command_index),
		.command_kind  (command_kind),
		.var_index     (var_index),
		.var_value     (var_value),
		.stray_end     (stray_end),
		.last          (last)
	);

endmodule
